FILE: design/reader_writer_lock_arbiter_core_assert.svh
// assertion macros for the reader-writer lock arbiter core
// expects clk and arst_n in the scope of each use
`ifndef READER_WRITER_LOCK_ARBITER_CORE_ASSERT_SVH
`define READER_WRITER_LOCK_ARBITER_CORE_ASSERT_SVH

// same-cycle implication, idle during reset
`define RWLA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, idle during reset
`define RWLA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rwla_pkg.sv
// shared types, constants and the control store of the lock arbiter sequencer
// no dependencies
`timescale 1ns / 1ps

package rwla_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int ID_BITS_DEF     = 8;

	localparam int FUNC_W   = 2;
	localparam int TARGET_W = 8;
	localparam int REPLY_W  = 3;
	localparam int COUNT_W  = 9;
	localparam int STEP_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_READER_OPEN  = 2'd0,
		FUNC_READER_CLOSE = 2'd1,
		FUNC_WRITER_OPEN  = 2'd2,
		FUNC_WRITER_CLOSE = 2'd3
	} func_t;

	typedef enum logic [REPLY_W-1:0] {
		REPLY_READER_GRANT = 3'd0,
		REPLY_READER_WAIT  = 3'd1,
		REPLY_WRITER_GRANT = 3'd2,
		REPLY_WRITER_WAIT  = 3'd3,
		REPLY_REJECT       = 3'd4
	} reply_t;

	typedef enum logic [3:0] {
		COND_TRUE,
		COND_WR_ZERO,
		COND_RW_ZERO,
		COND_RQ_FULL,
		COND_WQ_FULL,
		COND_RQ_ONE,
		COND_HANDOFF_RC,
		COND_HANDOFF_WC,
		COND_WC_ALONE
	} cond_t;

	typedef enum logic {
		GO_JUMP,
		GO_EXIT
	} go_t;

	typedef enum logic [1:0] {
		SRC_WHO,
		SRC_RQ,
		SRC_WQ
	} src_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC
	} cnt_op_t;

	// datapath status seen by the sequencer
	typedef struct packed {
		logic wr_zero;
		logic rw_zero;
		logic rq_full;
		logic wq_full;
		logic rq_one;
		logic handoff_rc;
		logic handoff_wc;
		logic wc_alone;
	} flags_t;

	// wait queue status
	typedef struct packed {
		logic full;
		logic empty;
		logic one;
	} fifo_stat_t;

	// one microinstruction
	typedef struct packed {
		cond_t               cond;
		logic                cond_neg;
		go_t                 go;
		logic [STEP_W-1:0]   target;
		logic                emit;
		src_t                src;
		reply_t              reply;
		cond_t               last_cond;
		logic                last_neg;
		cnt_op_t             rd_op;
		cnt_op_t             wr_op;
		logic                push_rq;
		logic                push_wq;
		logic                pop_rq;
		logic                pop_wq;
	} ctrl_t;

	// datapath controls for the current cycle
	typedef struct packed {
		logic    emit;
		src_t    src;
		reply_t  reply;
		logic    last;
		cnt_op_t rd_op;
		cnt_op_t wr_op;
		logic    push_rq;
		logic    push_wq;
		logic    pop_rq;
		logic    pop_wq;
	} op_t;

	// program addresses
	localparam logic [STEP_W-1:0] ST_RO        = 5'd0;
	localparam logic [STEP_W-1:0] ST_RO_GRANT  = 5'd1;
	localparam logic [STEP_W-1:0] ST_RO_FULL   = 5'd2;
	localparam logic [STEP_W-1:0] ST_RO_REJECT = 5'd3;
	localparam logic [STEP_W-1:0] ST_RO_WAIT   = 5'd4;
	localparam logic [STEP_W-1:0] ST_RC        = 5'd5;
	localparam logic [STEP_W-1:0] ST_RC_LONE   = 5'd6;
	localparam logic [STEP_W-1:0] ST_RC_HAND   = 5'd7;
	localparam logic [STEP_W-1:0] ST_RC_WGRANT = 5'd8;
	localparam logic [STEP_W-1:0] ST_WO        = 5'd9;
	localparam logic [STEP_W-1:0] ST_WO_GRANT  = 5'd10;
	localparam logic [STEP_W-1:0] ST_WO_FULL   = 5'd11;
	localparam logic [STEP_W-1:0] ST_WO_REJECT = 5'd12;
	localparam logic [STEP_W-1:0] ST_WO_WAIT   = 5'd13;
	localparam logic [STEP_W-1:0] ST_WC        = 5'd14;
	localparam logic [STEP_W-1:0] ST_WC_PICK   = 5'd15;
	localparam logic [STEP_W-1:0] ST_WC_WGRANT = 5'd16;
	localparam logic [STEP_W-1:0] ST_WC_DRAIN  = 5'd17;
	localparam logic [STEP_W-1:0] ST_WC_REFILL = 5'd18;

	function automatic logic [STEP_W-1:0] entry_step(input logic [FUNC_W-1:0] func);
		logic [STEP_W-1:0] s;
		case (func)
			FUNC_READER_OPEN:  s = ST_RO;
			FUNC_READER_CLOSE: s = ST_RC;
			FUNC_WRITER_OPEN:  s = ST_WO;
			default:           s = ST_WC;
		endcase
		return s;
	endfunction

	// control store
	function automatic ctrl_t ucode(input logic [STEP_W-1:0] addr);
		ctrl_t c;
		c = '0;
		c.go = GO_EXIT;
		c.last_cond = COND_TRUE;
		case (addr)
			ST_RO: begin
				c.cond = COND_WR_ZERO; c.cond_neg = 1'b1;
				c.go = GO_JUMP; c.target = ST_RO_FULL;
			end
			ST_RO_GRANT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_READER_GRANT;
				c.rd_op = CNT_INC;
			end
			ST_RO_FULL: begin
				c.cond = COND_RQ_FULL; c.cond_neg = 1'b1;
				c.go = GO_JUMP; c.target = ST_RO_WAIT;
			end
			ST_RO_REJECT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_REJECT;
			end
			ST_RO_WAIT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_READER_WAIT;
				c.push_rq = 1'b1;
			end
			ST_RC: begin
				c.cond = COND_HANDOFF_RC;
				c.go = GO_JUMP; c.target = ST_RC_HAND;
			end
			ST_RC_LONE: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_READER_GRANT;
				c.rd_op = CNT_DEC;
			end
			ST_RC_HAND: begin
				c.cond = COND_TRUE; c.cond_neg = 1'b1;
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_READER_GRANT;
				c.last_neg = 1'b1;
				c.rd_op = CNT_DEC;
			end
			ST_RC_WGRANT: begin
				c.emit = 1'b1; c.src = SRC_WQ; c.reply = REPLY_WRITER_GRANT;
				c.wr_op = CNT_INC; c.pop_wq = 1'b1;
			end
			ST_WO: begin
				c.cond = COND_RW_ZERO; c.cond_neg = 1'b1;
				c.go = GO_JUMP; c.target = ST_WO_FULL;
			end
			ST_WO_GRANT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_WRITER_GRANT;
				c.wr_op = CNT_INC;
			end
			ST_WO_FULL: begin
				c.cond = COND_WQ_FULL; c.cond_neg = 1'b1;
				c.go = GO_JUMP; c.target = ST_WO_WAIT;
			end
			ST_WO_REJECT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_REJECT;
			end
			ST_WO_WAIT: begin
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_WRITER_WAIT;
				c.push_wq = 1'b1;
			end
			ST_WC: begin
				c.cond = COND_WC_ALONE;
				c.emit = 1'b1; c.src = SRC_WHO; c.reply = REPLY_WRITER_GRANT;
				c.last_cond = COND_WC_ALONE;
				c.wr_op = CNT_DEC;
			end
			ST_WC_PICK: begin
				c.cond = COND_HANDOFF_WC; c.cond_neg = 1'b1;
				c.go = GO_JUMP; c.target = ST_WC_DRAIN;
			end
			ST_WC_WGRANT: begin
				c.emit = 1'b1; c.src = SRC_WQ; c.reply = REPLY_WRITER_GRANT;
				c.wr_op = CNT_INC; c.pop_wq = 1'b1;
			end
			ST_WC_DRAIN: begin
				c.cond = COND_RQ_ONE;
				c.emit = 1'b1; c.src = SRC_RQ; c.reply = REPLY_READER_GRANT;
				c.last_cond = COND_RQ_ONE;
				c.rd_op = CNT_INC; c.pop_rq = 1'b1;
			end
			ST_WC_REFILL: begin
				// one idle step so the queue read port catches up with the new head
				c.go = GO_JUMP; c.target = ST_WC_DRAIN;
			end
			default: begin
				c.go = GO_EXIT;
			end
		endcase
		return c;
	endfunction

endpackage

FILE: design/rwla_wait_fifo.sv
// wait queue: circular memory with head, tail and fill count, registered read at the head
// depends on rwla_pkg
`timescale 1ns / 1ps

module rwla_wait_fifo #(
	parameter int DEPTH = rwla_pkg::QUEUE_DEPTH_DEF,
	parameter int WIDTH = rwla_pkg::ID_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  logic [WIDTH-1:0]       wdata,
	input  logic                   pop,
	output logic [WIDTH-1:0]       rdata,
	output rwla_pkg::fifo_stat_t   stat
);

	localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(DEPTH);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [WIDTH-1:0]  rdata_q;
	logic [PTR_W-1:0]  head_q;
	logic [PTR_W-1:0]  tail_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign do_push = push && (fill_q != FILL_FULL);
	assign do_pop  = pop && (fill_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[tail_q] <= wdata;
		end
		rdata_q <= mem_q[head_q];
	end

	assign rdata      = rdata_q;
	assign stat.full  = (fill_q == FILL_FULL);
	assign stat.empty = (fill_q == '0);
	assign stat.one   = (fill_q == FILL_W'(1));

endmodule

FILE: design/rwla_sequencer.sv
// step counter, control store fetch and condition select of the lock arbiter
// depends on rwla_pkg
`timescale 1ns / 1ps

module rwla_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [rwla_pkg::FUNC_W-1:0]       func,
	input  rwla_pkg::flags_t                  flags,
	output logic                              busy,
	output rwla_pkg::op_t                     op
);

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} seq_state_t;

	seq_state_t                      state_q;
	logic [rwla_pkg::STEP_W-1:0]     step_q;
	rwla_pkg::ctrl_t                 ctrl;
	logic                            cond_hit;
	logic                            last_hit;

	function automatic logic pick(input rwla_pkg::flags_t f, input rwla_pkg::cond_t c);
		logic r;
		case (c)
			rwla_pkg::COND_WR_ZERO:    r = f.wr_zero;
			rwla_pkg::COND_RW_ZERO:    r = f.rw_zero;
			rwla_pkg::COND_RQ_FULL:    r = f.rq_full;
			rwla_pkg::COND_WQ_FULL:    r = f.wq_full;
			rwla_pkg::COND_RQ_ONE:     r = f.rq_one;
			rwla_pkg::COND_HANDOFF_RC: r = f.handoff_rc;
			rwla_pkg::COND_HANDOFF_WC: r = f.handoff_wc;
			rwla_pkg::COND_WC_ALONE:   r = f.wc_alone;
			default:                   r = 1'b1;
		endcase
		return r;
	endfunction

	always_comb begin
		ctrl     = rwla_pkg::ucode(step_q);
		cond_hit = pick(flags, ctrl.cond) ^ ctrl.cond_neg;
		last_hit = pick(flags, ctrl.last_cond) ^ ctrl.last_neg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				SEQ_IDLE: begin
					if (start) begin
						step_q  <= rwla_pkg::entry_step(func);
						state_q <= SEQ_RUN;
					end
				end
				SEQ_RUN: begin
					if (cond_hit) begin
						if (ctrl.go == rwla_pkg::GO_EXIT) begin
							state_q <= SEQ_IDLE;
						end else begin
							step_q <= ctrl.target;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				default: begin
					state_q <= SEQ_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == SEQ_RUN);

	// controls are quiet while idle
	always_comb begin
		op = '0;
		if (state_q == SEQ_RUN) begin
			op.emit    = ctrl.emit;
			op.src     = ctrl.src;
			op.reply   = ctrl.reply;
			op.last    = last_hit;
			op.rd_op   = ctrl.rd_op;
			op.wr_op   = ctrl.wr_op;
			op.push_rq = ctrl.push_rq;
			op.push_wq = ctrl.push_wq;
			op.pop_rq  = ctrl.pop_rq;
			op.pop_wq  = ctrl.pop_wq;
		end
	end

endmodule

FILE: design/reader_writer_lock_arbiter_core.sv
// Reader-writer lock arbiter core.
// Request channel: func and requester are taken at a rising edge with start high
// and busy low. Result channel: target, reply and last are valid for exactly one
// cycle while strobe is high; the receiver cannot stall, so every result must be
// taken in the cycle it is shown. last marks the final result of a request.
// The first result of every request goes to the requester.
// A request occupies the block for its program steps plus an idle state before
// the next request is taken. An open tests the counts and its queue before it
// grants, queues or rejects; a writer close that grants waiting readers runs a
// drain step for each of them. The sequencer fetches one control word per cycle,
// and the queue read port needs an extra step between drained readers.
// Reset clears both counts, both queues and the sequencer; the queue memories
// themselves are not cleared and need no clearing pass.
// depends on rwla_pkg, rwla_sequencer, rwla_wait_fifo, reader_writer_lock_arbiter_core_assert.svh
`timescale 1ns / 1ps

`include "reader_writer_lock_arbiter_core_assert.svh"

module reader_writer_lock_arbiter_core #(
	parameter int QUEUE_DEPTH = rwla_pkg::QUEUE_DEPTH_DEF,
	parameter int ID_BITS     = rwla_pkg::ID_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rwla_pkg::FUNC_W-1:0]         func,
	input  logic [rwla_pkg::TARGET_W-1:0]       requester,
	output logic                                strobe,
	output logic [rwla_pkg::TARGET_W-1:0]       target,
	output logic [rwla_pkg::REPLY_W-1:0]        reply,
	output logic                                last
);

	localparam int ID_W = (ID_BITS < rwla_pkg::TARGET_W) ? ID_BITS : rwla_pkg::TARGET_W;
	localparam logic [rwla_pkg::TARGET_W-1:0] ID_MASK =
		rwla_pkg::TARGET_W'((1 << ID_W) - 1);

	logic [rwla_pkg::TARGET_W-1:0] who_q;
	logic [rwla_pkg::COUNT_W-1:0]  readers_q;
	logic [rwla_pkg::COUNT_W-1:0]  writers_q;
	logic                          strobe_q;
	logic [rwla_pkg::TARGET_W-1:0] target_q;
	logic [rwla_pkg::REPLY_W-1:0]  reply_q;
	logic                          last_q;

	rwla_pkg::op_t        op;
	rwla_pkg::flags_t     flags;
	rwla_pkg::fifo_stat_t rq_stat;
	rwla_pkg::fifo_stat_t wq_stat;
	logic [ID_W-1:0]      rq_rdata;
	logic [ID_W-1:0]      wq_rdata;
	logic                 accept;

	assign accept = start && !busy;

	rwla_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (func),
		.flags  (flags),
		.busy   (busy),
		.op     (op)
	);

	rwla_wait_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ID_W)
	) u_rq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op.push_rq),
		.wdata  (who_q[ID_W-1:0]),
		.pop    (op.pop_rq),
		.rdata  (rq_rdata),
		.stat   (rq_stat)
	);

	rwla_wait_fifo #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ID_W)
	) u_wq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op.push_wq),
		.wdata  (who_q[ID_W-1:0]),
		.pop    (op.pop_wq),
		.rdata  (wq_rdata),
		.stat   (wq_stat)
	);

	always_comb begin
		flags.wr_zero    = (writers_q == '0);
		flags.rw_zero    = (writers_q == '0) && (readers_q == '0);
		flags.rq_full    = rq_stat.full;
		flags.wq_full    = wq_stat.full;
		flags.rq_one     = rq_stat.one;
		// this close takes the reader count to zero and a writer is waiting
		flags.handoff_rc = (readers_q == rwla_pkg::COUNT_W'(1)) && !wq_stat.empty;
		flags.handoff_wc = !wq_stat.empty && (readers_q == '0);
		flags.wc_alone   = !flags.handoff_wc && rq_stat.empty;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readers_q <= '0;
			writers_q <= '0;
			strobe_q  <= 1'b0;
		end else begin
			strobe_q <= op.emit;
			case (op.rd_op)
				rwla_pkg::CNT_INC: begin
					if (readers_q != rwla_pkg::COUNT_MAX) readers_q <= readers_q + 1'b1;
				end
				rwla_pkg::CNT_DEC: begin
					if (readers_q != '0) readers_q <= readers_q - 1'b1;
				end
				default: begin
				end
			endcase
			case (op.wr_op)
				rwla_pkg::CNT_INC: begin
					if (writers_q != rwla_pkg::COUNT_MAX) writers_q <= writers_q + 1'b1;
				end
				rwla_pkg::CNT_DEC: begin
					if (writers_q != '0) writers_q <= writers_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			who_q <= requester & ID_MASK;
		end
		if (op.emit) begin
			case (op.src)
				rwla_pkg::SRC_RQ: target_q <= rwla_pkg::TARGET_W'(rq_rdata);
				rwla_pkg::SRC_WQ: target_q <= rwla_pkg::TARGET_W'(wq_rdata);
				default:          target_q <= who_q;
			endcase
			reply_q <= op.reply;
			last_q  <= op.last;
		end
	end

	assign strobe = strobe_q;
	assign target = target_q;
	assign reply  = reply_q;
	assign last   = last_q;

	`RWLA_ASSERT_NXT(a_accept_busy, accept, busy, "accepted request did not raise busy")
	`RWLA_ASSERT_IMP(a_strobe_in_run, strobe, $past(busy), "result without a running request")
	`RWLA_ASSERT_IMP(a_end_last, $fell(busy), strobe && last, "request ended without a last result")
	`RWLA_ASSERT_IMP(a_reject_last, strobe && (reply == rwla_pkg::REPLY_REJECT), last, "reject not final")

endmodule

FILE: test/rwla_lock_checker.sv
// lock arbiter checker: watches the request and response channels, keeps its own lock state
// and compares every response with the predicted one. depends on rwla_pkg
`timescale 1ns / 1ps

module rwla_lock_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [rwla_pkg::FUNC_W-1:0]   func,
	input  logic [rwla_pkg::TARGET_W-1:0] requester,
	input  logic                          strobe,
	input  logic [rwla_pkg::TARGET_W-1:0] target,
	input  logic [rwla_pkg::REPLY_W-1:0]  reply,
	input  logic                          last,
	output int                            mismatches,
	output int                            pending
);

	typedef struct packed {
		logic [rwla_pkg::TARGET_W-1:0] dest;
		rwla_pkg::reply_t              code;
		logic                          tail;
	} response_t;

	logic [rwla_pkg::COUNT_W-1:0]  readers;
	logic [rwla_pkg::COUNT_W-1:0]  writers;
	logic [rwla_pkg::TARGET_W-1:0] reader_line[$];
	logic [rwla_pkg::TARGET_W-1:0] writer_line[$];
	response_t                     due[$];
	response_t                     want;

	function automatic logic [rwla_pkg::COUNT_W-1:0] count_inc(
		input logic [rwla_pkg::COUNT_W-1:0] c);
		return (c == rwla_pkg::COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [rwla_pkg::COUNT_W-1:0] count_dec(
		input logic [rwla_pkg::COUNT_W-1:0] c);
		return (c == '0) ? c : c - 1'b1;
	endfunction

	task automatic report(input string field, input int got, input int exp_val);
		$display("%0t ns: %s mismatch, got %0d want %0d", $time, field, got, exp_val);
		mismatches = mismatches + 1;
	endtask

	task automatic post(input logic [rwla_pkg::TARGET_W-1:0] id, input rwla_pkg::reply_t code);
		response_t r;
		r.dest = id;
		r.code = code;
		r.tail = 1'b0;
		due.push_back(r);
	endtask

	task automatic predict_request(input rwla_pkg::func_t kind,
		input logic [rwla_pkg::TARGET_W-1:0] who);
		logic      was_busy;
		response_t r;
		case (kind)
			rwla_pkg::FUNC_READER_OPEN: begin
				if (writers == '0) begin
					readers = count_inc(readers);
					post(who, rwla_pkg::REPLY_READER_GRANT);
				end else if (reader_line.size() < rwla_pkg::QUEUE_DEPTH_DEF) begin
					reader_line.push_back(who);
					post(who, rwla_pkg::REPLY_READER_WAIT);
				end else begin
					post(who, rwla_pkg::REPLY_REJECT);
				end
			end
			rwla_pkg::FUNC_READER_CLOSE: begin
				was_busy = (readers != '0);
				readers = count_dec(readers);
				post(who, rwla_pkg::REPLY_READER_GRANT);
				// last reader out hands the lock to the oldest waiting writer
				if (was_busy && readers == '0 && writer_line.size() > 0) begin
					writers = count_inc(writers);
					post(writer_line.pop_front(), rwla_pkg::REPLY_WRITER_GRANT);
				end
			end
			rwla_pkg::FUNC_WRITER_OPEN: begin
				if (readers == '0 && writers == '0) begin
					writers = count_inc(writers);
					post(who, rwla_pkg::REPLY_WRITER_GRANT);
				end else if (writer_line.size() < rwla_pkg::QUEUE_DEPTH_DEF) begin
					writer_line.push_back(who);
					post(who, rwla_pkg::REPLY_WRITER_WAIT);
				end else begin
					post(who, rwla_pkg::REPLY_REJECT);
				end
			end
			default: begin
				writers = count_dec(writers);
				post(who, rwla_pkg::REPLY_WRITER_GRANT);
				if (writer_line.size() > 0 && readers == '0) begin
					writers = count_inc(writers);
					post(writer_line.pop_front(), rwla_pkg::REPLY_WRITER_GRANT);
				end else begin
					// release every waiting reader, oldest first
					while (reader_line.size() > 0) begin
						readers = count_inc(readers);
						post(reader_line.pop_front(), rwla_pkg::REPLY_READER_GRANT);
					end
				end
			end
		endcase
		r = due.pop_back();
		r.tail = 1'b1;
		due.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readers = '0;
			writers = '0;
			reader_line.delete();
			writer_line.delete();
			due.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (start && !busy)
				predict_request(rwla_pkg::func_t'(func), requester);
			if (strobe) begin
				if (due.size() == 0) begin
					report("unexpected response target", target, -1);
				end else begin
					want = due.pop_front();
					if (target !== want.dest)
						report("target", target, want.dest);
					if (reply !== want.code)
						report("reply", reply, want.code);
					if (last !== want.tail)
						report("last", last, want.tail);
				end
			end
			pending <= due.size();
		end
	end

endmodule

FILE: test/reader_writer_lock_arbiter_core_tb.sv
// testbench top for the reader-writer lock arbiter core: drives lock requests and gives the verdict
// depends on rwla_pkg, reader_writer_lock_arbiter_core and rwla_lock_checker
`timescale 1ns / 1ps

module reader_writer_lock_arbiter_core_tb;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PHASE_ITEMS  = 80;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [rwla_pkg::FUNC_W-1:0]   func;
	logic [rwla_pkg::TARGET_W-1:0] requester;
	logic                          strobe;
	logic [rwla_pkg::TARGET_W-1:0] target;
	logic [rwla_pkg::REPLY_W-1:0]  reply;
	logic                          last;
	int                            mismatches;
	int                            pending;
	int                            cycle_count = 0;
	int                            idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	reader_writer_lock_arbiter_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.func      (func),
		.requester (requester),
		.strobe    (strobe),
		.target    (target),
		.reply     (reply),
		.last      (last)
	);

	rwla_lock_checker lock_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.func       (func),
		.requester  (requester),
		.strobe     (strobe),
		.target     (target),
		.reply      (reply),
		.last       (last),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// random gaps between requests, with junk on the request fields while start is low
	task automatic sender_pause();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			func <= rwla_pkg::FUNC_W'($urandom_range(3));
			requester <= rwla_pkg::TARGET_W'($urandom_range(255));
			@(posedge clk);
		end
	endtask

	task automatic issue(input rwla_pkg::func_t kind,
		input logic [rwla_pkg::TARGET_W-1:0] id);
		sender_pause();
		start <= 1'b1;
		func <= kind;
		requester <= id;
		do @(posedge clk); while (busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// runs of one kind fill the wait queues and reach the long drains
	task automatic random_run(inout int sent);
		rwla_pkg::func_t kind;
		int              pick;
		int              run;
		pick = $urandom_range(9);
		if (pick < 4)
			kind = rwla_pkg::FUNC_READER_OPEN;
		else if (pick < 6)
			kind = rwla_pkg::FUNC_READER_CLOSE;
		else if (pick < 8)
			kind = rwla_pkg::FUNC_WRITER_OPEN;
		else
			kind = rwla_pkg::FUNC_WRITER_CLOSE;
		run = ($urandom_range(99) < 15) ? $urandom_range(8, 18) : 1;
		repeat (run) begin
			issue(kind, rwla_pkg::TARGET_W'($urandom_range(255)));
			sent++;
		end
	endtask

	initial begin
		int sent;
		arst_n = 1'b0;
		start = 1'b0;
		func = rwla_pkg::FUNC_READER_OPEN;
		requester = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// closes with nothing open, then a writer holding the lock while a second writer waits and the reader queue fills
		issue(rwla_pkg::FUNC_READER_CLOSE, 8'hFF);
		issue(rwla_pkg::FUNC_WRITER_CLOSE, 8'h00);
		issue(rwla_pkg::FUNC_WRITER_OPEN, 8'h01);
		issue(rwla_pkg::FUNC_WRITER_OPEN, 8'h02);
		for (int i = 0; i < rwla_pkg::QUEUE_DEPTH_DEF; i++)
			issue(rwla_pkg::FUNC_READER_OPEN, rwla_pkg::TARGET_W'((i << 4) | (15 - i)));
		issue(rwla_pkg::FUNC_READER_OPEN, 8'h5A);
		// writer to writer handoff, then a close that releases the full reader queue
		issue(rwla_pkg::FUNC_WRITER_CLOSE, 8'h01);
		issue(rwla_pkg::FUNC_WRITER_CLOSE, 8'h02);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			idle_pct = (phase == 0) ? 16 : (phase == 1) ? 57 : 0;
			sent = 0;
			while (sent < PHASE_ITEMS)
				random_run(sent);
			if (phase == 0)
				wait_drained();
		end

		wait_drained();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
